// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// prop must hold in the cycle after trig
`define ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, trig, prop, msg)
`endif
`endif

// ===== hw/rtl/isotp_pkg.sv =====
`default_nettype none
package isotp_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 29;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESPONSE_ID    = 3'd0,
        CFG_TIMEOUT_TICKS  = 3'd1,
        CFG_MAX_MSG_LEN    = 3'd2,
        CFG_FC_BLOCK_SIZE  = 3'd3,
        CFG_FC_SEP_TIME    = 3'd4,
        CFG_PAD_VALUE      = 3'd5
    } t_cfg_idx;

    localparam logic [28:0] RST_RESPONSE_ID   = 29'h7BB;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd150;
    localparam logic [11:0] RST_MAX_MSG_LEN   = 12'd256;
    localparam logic [7:0]  RST_FC_BLOCK_SIZE = 8'd0;
    localparam logic [7:0]  RST_FC_SEP_TIME   = 8'd20;
    localparam logic [7:0]  RST_PAD_VALUE     = 8'hFF;

    // protocol control information types (upper nibble of byte 0)
    localparam logic [3:0] PCI_SF = 4'd0;
    localparam logic [3:0] PCI_FF = 4'd1;
    localparam logic [3:0] PCI_CF = 4'd2;

    localparam logic [3:0]  CAN_DLC_FULL = 4'd8;
    localparam logic [3:0]  SF_MAX_LEN   = 4'd7;
    localparam logic [11:0] FF_MIN_LEN   = 12'd8;
    localparam logic [2:0]  FF_PAYLOAD   = 3'd6;
    localparam logic [2:0]  CF_PAYLOAD   = 3'd7;
    localparam logic [3:0]  FC_BYTES     = 4'd8;
    localparam logic [3:0]  FF_NEXT_SN   = 4'd1;
    localparam logic [7:0]  FC_CTS       = 8'h30;

    // byte slots of the flow-control frame
    localparam logic [2:0] FC_POS_FS = 3'd0;
    localparam logic [2:0] FC_POS_BS = 3'd1;
    localparam logic [2:0] FC_POS_ST = 3'd2;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_FC      = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_DLC    = 3'd1,
        ST_TIMEOUT    = 3'd2,
        ST_BAD_SF_LEN = 3'd3,
        ST_OVERFLOW   = 3'd4,
        ST_WRONG_SN   = 3'd5,
        ST_UNEXPECTED = 3'd6,
        ST_WRONG_TYPE = 3'd7
    } t_status;

    typedef struct packed {
        logic        cmd;
        logic [28:0] frame_id;
        logic [3:0]  frame_dlc;
        logic [7:0]  data0;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [7:0]  data3;
        logic [7:0]  data4;
        logic [7:0]  data5;
        logic [7:0]  data6;
        logic [7:0]  data7;
    } t_frame;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] position;
        logic [7:0]  value;
        logic [11:0] message_length;
        t_status     status;
        logic        last;
    } t_result;

    // one classified frame: payload bytes, then flow control, then complete,
    // or a single error result
    typedef struct packed {
        logic            is_err;
        t_status         status;
        logic [11:0]     msg_len;
        logic [2:0]      n_pay;
        logic [11:0]     base;
        logic [6:0][7:0] bytes;
        logic            with_fc;
        logic            with_done;
    } t_job;

    typedef struct packed {
        logic [28:0] response_id;
        logic [15:0] timeout_ticks;
        logic [11:0] max_msg_len;
    } t_front_cfg;

    typedef struct packed {
        logic [7:0] block_size;
        logic [7:0] sep_time;
        logic [7:0] pad;
    } t_fc_cfg;

endpackage
`default_nettype wire

// ===== hw/rtl/isotp_in_if.sv =====
`default_nettype none
interface isotp_in_if import isotp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_frame data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/isotp_out_if.sv =====
`default_nettype none
interface isotp_out_if import isotp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/isotp_front.sv =====
`default_nettype none
`include "assert_macros.svh"
module isotp_front import isotp_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    isotp_in_if.sink    i_in,
    input  t_front_cfg  i_cfg,
    output logic        o_job_valid,
    output t_job        o_job,
    input  wire         i_job_ready
);

    logic        r_in_progress, n_in_progress;
    logic [11:0] r_total, n_total;
    logic [11:0] r_rc, n_rc;
    logic [3:0]  r_seq, n_seq;
    logic [15:0] r_idle, n_idle;

    logic        accept;
    logic        clr;
    logic [3:0]  pci;
    logic [3:0]  sf_len;
    logic [11:0] ff_len;
    logic [11:0] rem;
    logic [2:0]  n_cf;
    logic [11:0] rc_next;
    logic [11:0] open_len;
    t_frame      f;

    function automatic t_job make_err(input t_status s, input logic [11:0] len);
        t_job j;
        j         = '0;
        j.is_err  = 1'b1;
        j.status  = s;
        j.msg_len = len;
        return j;
    endfunction

    assign i_in.ready = i_job_ready;
    assign accept     = i_in.valid && i_job_ready;
    assign f          = i_in.data;

    assign pci      = f.data0[7:4];
    assign sf_len   = f.data0[3:0];
    assign ff_len   = {f.data0[3:0], f.data1};
    assign rem      = r_total - r_rc;
    assign n_cf     = (rem > 12'(CF_PAYLOAD)) ? CF_PAYLOAD : rem[2:0];
    assign rc_next  = r_rc + 12'(n_cf);
    assign open_len = r_in_progress ? r_total : '0;

    always_comb begin
        n_in_progress = r_in_progress;
        n_total       = r_total;
        n_rc          = r_rc;
        n_seq         = r_seq;
        n_idle        = r_idle;
        o_job         = '0;
        o_job_valid   = 1'b0;
        clr           = 1'b0;
        if (accept) begin
            if (f.cmd) begin
                if (r_in_progress) begin
                    if (r_idle >= i_cfg.timeout_ticks) begin
                        o_job       = make_err(ST_TIMEOUT, r_total);
                        o_job_valid = 1'b1;
                        clr         = 1'b1;
                    end else begin
                        n_idle = r_idle + 16'd1;
                    end
                end
            end else if (f.frame_dlc != CAN_DLC_FULL) begin
                o_job       = make_err(ST_BAD_DLC, open_len);
                o_job_valid = 1'b1;
                clr         = 1'b1;
            end else if (f.frame_id == i_cfg.response_id) begin
                n_idle      = '0;
                o_job_valid = 1'b1;
                case (pci)
                    PCI_SF: begin
                        if (r_in_progress) begin
                            o_job = make_err(ST_UNEXPECTED, r_total);
                        end else if (sf_len > SF_MAX_LEN) begin
                            o_job = make_err(ST_BAD_SF_LEN, 12'(sf_len));
                        end else begin
                            o_job.status    = ST_OK;
                            o_job.msg_len   = 12'(sf_len);
                            o_job.n_pay     = sf_len[2:0];
                            o_job.base      = '0;
                            o_job.bytes     = {f.data7, f.data6, f.data5, f.data4,
                                               f.data3, f.data2, f.data1};
                            o_job.with_done = 1'b1;
                        end
                        clr = 1'b1;
                    end
                    PCI_FF: begin
                        if (r_in_progress || ff_len < FF_MIN_LEN) begin
                            o_job = make_err(ST_UNEXPECTED, open_len);
                            clr   = 1'b1;
                        end else if (ff_len > i_cfg.max_msg_len) begin
                            o_job = make_err(ST_OVERFLOW, ff_len);
                            clr   = 1'b1;
                        end else begin
                            o_job.status  = ST_OK;
                            o_job.msg_len = ff_len;
                            o_job.n_pay   = FF_PAYLOAD;
                            o_job.base    = '0;
                            o_job.bytes   = {8'h00, f.data7, f.data6, f.data5,
                                             f.data4, f.data3, f.data2};
                            o_job.with_fc = 1'b1;
                            n_in_progress = 1'b1;
                            n_total       = ff_len;
                            n_rc          = 12'(FF_PAYLOAD);
                            n_seq         = FF_NEXT_SN;
                        end
                    end
                    PCI_CF: begin
                        if (!r_in_progress) begin
                            o_job = make_err(ST_UNEXPECTED, '0);
                            clr   = 1'b1;
                        end else if (f.data0[3:0] != r_seq) begin
                            o_job = make_err(ST_WRONG_SN, r_total);
                            clr   = 1'b1;
                        end else if (r_rc >= r_total) begin
                            o_job = make_err(ST_UNEXPECTED, r_total);
                            clr   = 1'b1;
                        end else begin
                            o_job.status    = ST_OK;
                            o_job.msg_len   = r_total;
                            o_job.n_pay     = n_cf;
                            o_job.base      = r_rc;
                            o_job.bytes     = {f.data7, f.data6, f.data5, f.data4,
                                               f.data3, f.data2, f.data1};
                            o_job.with_done = (rc_next >= r_total);
                            n_rc            = rc_next;
                            n_seq           = r_seq + 4'd1;
                            clr             = (rc_next >= r_total);
                        end
                    end
                    default: begin
                        o_job = make_err(ST_WRONG_TYPE, open_len);
                        clr   = 1'b1;
                    end
                endcase
            end
        end
        // errors and completed messages drop all message state
        if (clr) begin
            n_in_progress = 1'b0;
            n_total       = '0;
            n_rc          = '0;
            n_seq         = '0;
            n_idle        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_progress <= 1'b0;
            r_total       <= '0;
            r_rc          <= '0;
            r_seq         <= '0;
            r_idle        <= '0;
        end else begin
            r_in_progress <= n_in_progress;
            r_total       <= n_total;
            r_rc          <= n_rc;
            r_seq         <= n_seq;
            r_idle        <= n_idle;
        end
    end

    `ASSERT_ALWAYS(a_idle_state_clear, i_clk, i_rst_n, !r_in_progress |-> (r_total == '0 && r_rc == '0 && r_seq == '0 && r_idle == '0), "message state not clear while idle")
    `ASSERT_ALWAYS(a_open_incomplete, i_clk, i_rst_n, r_in_progress |-> (r_rc < r_total), "open message already complete")
    `ASSERT_ALWAYS(a_push_has_room, i_clk, i_rst_n, o_job_valid |-> i_job_ready, "job pushed into full queue")

endmodule
`default_nettype wire

// ===== hw/rtl/isotp_queue.sv =====
`default_nettype none
module isotp_queue import isotp_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_wr_valid,
    input  t_job  i_wr_data,
    output logic  o_wr_ready,
    output logic  o_rd_valid,
    output t_job  o_rd_data,
    input  wire   i_rd_pop
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                push;
    logic                pop;

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_wr_ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = i_rd_pop && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/isotp_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module isotp_back import isotp_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_job_valid,
    input  t_job        i_job,
    output logic        o_job_pop,
    input  t_fc_cfg     i_fc,
    isotp_out_if.source o_out
);

    logic [3:0] r_step;
    logic       r_out_valid;
    t_result    r_out;

    logic [3:0] total;
    logic [3:0] fc_idx;
    logic       advance;
    logic       load;
    t_result    res;

    assign total = i_job.is_err ? 4'd1
                 : 4'({1'b0, i_job.n_pay}) + (i_job.with_fc ? FC_BYTES : 4'd0)
                   + 4'(i_job.with_done);
    assign fc_idx = r_step - {1'b0, i_job.n_pay};

    always_comb begin
        res                = '0;
        res.message_length = i_job.msg_len;
        res.status         = ST_OK;
        res.last           = (r_step == total - 4'd1);
        if (i_job.is_err) begin
            res.kind   = KIND_ERROR;
            res.status = i_job.status;
        end else if (r_step < {1'b0, i_job.n_pay}) begin
            res.kind     = KIND_PAYLOAD;
            res.position = i_job.base + 12'(r_step);
            res.value    = i_job.bytes[r_step[2:0]];
        end else if (i_job.with_fc && fc_idx < FC_BYTES) begin
            res.kind     = KIND_FC;
            res.position = 12'(fc_idx);
            case (fc_idx[2:0])
                FC_POS_FS: res.value = FC_CTS;
                FC_POS_BS: res.value = i_fc.block_size;
                FC_POS_ST: res.value = i_fc.sep_time;
                default:   res.value = i_fc.pad;
            endcase
        end else begin
            res.kind = KIND_DONE;
        end
    end

    // the output register frees up when empty or when its result transfers
    assign advance   = !r_out_valid || o_out.ready;
    assign load      = advance && i_job_valid;
    assign o_job_pop = load && res.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= i_job_valid;
            end
            if (load) begin
                r_step <= res.last ? 4'd0 : r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `ASSERT_ALWAYS(a_step_in_range, i_clk, i_rst_n, i_job_valid |-> (r_step < total), "result step past end of job")
    `ASSERT_ALWAYS(a_error_is_last, i_clk, i_rst_n, (r_out_valid && r_out.kind == KIND_ERROR) |-> r_out.last, "error result not marked last")
    `ASSERT_NEXT(a_pop_restarts, i_clk, i_rst_n, o_job_pop, r_step == 4'd0, "step not restarted after pop")

endmodule
`default_nettype wire

// ===== hw/rtl/isotp_message_reassembler_top.sv =====
`default_nettype none
// ISO-TP receive reassembler.
// i_in carries one item per transfer: a received CAN frame (cmd 0) or one
// time tick (cmd 1). o_out carries result items one byte at a time: payload
// bytes, flow-control bytes to transmit, message complete, or an error with
// its status; last marks the final result of each input item with results.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while the block is idle, which the block itself does
// not enforce; indexes past pad_value are ignored. A front stage decodes
// each item as it transfers and, where it yields results, pushes a job
// into a two-entry queue; a back stage expands the job into results, one
// per cycle while the receiver accepts them. The front keeps taking items
// while the queue has room. The first result of an item passes through the
// queue and then the output register before it is valid on o_out. An item
// yields at most 14 results (a first frame).
// Reset returns registers to their defaults, closes any open message and
// empties the queue and output register.
// When the receiver stalls, the output register holds its result, the
// queue fills and then i_in.ready drops until results move again.
module isotp_message_reassembler_top import isotp_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    isotp_in_if.sink              i_in,
    isotp_out_if.source           o_out,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [28:0] r_response_id;
    logic [15:0] r_timeout_ticks;
    logic [11:0] r_max_msg_len;
    logic [7:0]  r_fc_block_size;
    logic [7:0]  r_fc_sep_time;
    logic [7:0]  r_pad_value;

    t_front_cfg front_cfg;
    t_fc_cfg    fc_cfg;
    logic       job_valid;
    t_job       job;
    logic       job_ready;
    logic       q_valid;
    t_job       q_job;
    logic       q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_response_id   <= RST_RESPONSE_ID;
            r_timeout_ticks <= RST_TIMEOUT_TICKS;
            r_max_msg_len   <= RST_MAX_MSG_LEN;
            r_fc_block_size <= RST_FC_BLOCK_SIZE;
            r_fc_sep_time   <= RST_FC_SEP_TIME;
            r_pad_value     <= RST_PAD_VALUE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RESPONSE_ID:   r_response_id   <= i_cfg_data[28:0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[15:0];
                CFG_MAX_MSG_LEN:   r_max_msg_len   <= i_cfg_data[11:0];
                CFG_FC_BLOCK_SIZE: r_fc_block_size <= i_cfg_data[7:0];
                CFG_FC_SEP_TIME:   r_fc_sep_time   <= i_cfg_data[7:0];
                CFG_PAD_VALUE:     r_pad_value     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign front_cfg.response_id   = r_response_id;
    assign front_cfg.timeout_ticks = r_timeout_ticks;
    assign front_cfg.max_msg_len   = r_max_msg_len;
    assign fc_cfg.block_size       = r_fc_block_size;
    assign fc_cfg.sep_time         = r_fc_sep_time;
    assign fc_cfg.pad              = r_pad_value;

    isotp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (front_cfg),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    isotp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (job_valid),
        .i_wr_data  (job),
        .o_wr_ready (job_ready),
        .o_rd_valid (q_valid),
        .o_rd_data  (q_job),
        .i_rd_pop   (q_pop)
    );

    isotp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .i_fc        (fc_cfg),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
